FILE: hdl/bms_pkg.sv
// bms_pkg: shared constants, request types and helper functions of the bump map shader
`default_nettype none
package bms_pkg;

	localparam int NUM_W  = 44;
	localparam int DEN_W  = 28;
	localparam int QUO_W  = 16;
	localparam int RAD_W  = 50;
	localparam int ROOT_W = 25;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic signed [15:0] L_COMP   = 16'sd9459;
	localparam logic signed [15:0] S_XY     = 16'sd10289;
	localparam logic signed [15:0] S_Z      = 16'sd7532;
	localparam logic signed [19:0] DOT_BIAS = 20'sd9830;
	localparam logic signed [19:0] V_FLAT   = -20'sd528;
	localparam logic [3:0] ATAN_LAST = 4'd13;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] rad;
	} root_req_t;

	function automatic logic signed [17:0] atan_step(input logic [3:0] i);
		logic signed [17:0] r;
		unique case (i)
			4'd0:    r = 18'sd12868;
			4'd1:    r = 18'sd7596;
			4'd2:    r = 18'sd4014;
			4'd3:    r = 18'sd2037;
			4'd4:    r = 18'sd1023;
			4'd5:    r = 18'sd512;
			4'd6:    r = 18'sd256;
			4'd7:    r = 18'sd128;
			4'd8:    r = 18'sd64;
			4'd9:    r = 18'sd32;
			4'd10:   r = 18'sd16;
			4'd11:   r = 18'sd8;
			4'd12:   r = 18'sd4;
			4'd13:   r = 18'sd2;
			default: r = 18'sd0;
		endcase
		return r;
	endfunction

	// divide by 2^14, rounding half away from zero
	function automatic logic signed [47:0] rnd_q14(input logic signed [47:0] a);
		logic [47:0] mag;
		logic [47:0] q;
		mag = a[47] ? 48'(-a) : 48'(a);
		q   = (mag + 48'd8192) >> 14;
		return a[47] ? -$signed(q) : $signed(q);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/bms_store.sv
// bms_store: height map memory with clearing pass after reset
`default_nettype none
module bms_store #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    we,
	input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] addr,
	input  wire logic [15:0]                             wdata,
	output logic      [15:0]                             rdata,
	output logic                                         ready
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [15:0]   mem [DEPTH];
	logic [15:0]   rdata_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;
	logic          wr_en;
	logic [AW-1:0] mem_addr;
	logic [15:0]   wr_data;

	always_comb begin
		wr_en    = clr_busy_q | we;
		mem_addr = clr_busy_q ? clr_addr_q : addr;
		wr_data  = clr_busy_q ? 16'd0 : wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[mem_addr] <= wr_data;
		rdata_q <= mem[mem_addr];
	end

	assign rdata = rdata_q;
	assign ready = !clr_busy_q;

endmodule
`default_nettype wire

FILE: hdl/bms_root.sv
// bms_root: iterative integer square root, one result bit per cycle
`default_nettype none
module bms_root (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bms_pkg::root_req_t        req,
	output logic                           done,
	output logic [bms_pkg::ROOT_W-1:0]     root
);
	localparam int RW = bms_pkg::ROOT_W;
	localparam int VW = bms_pkg::RAD_W;
	localparam int MW = RW + 2;
	localparam int CW = $clog2(RW);

	logic [MW-1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [VW-1:0] rad_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [MW+1:0] r2;
	logic [MW+1:0] trial;

	always_comb begin
		r2    = {rem_q, rad_q[VW-1 -: 2]};
		trial = (MW+2)'({root_q, 2'b01});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			root_q <= '0;
			rad_q  <= req.rad;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (r2 >= trial) begin
				rem_q  <= MW'(r2 - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= MW'(r2);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

FILE: hdl/bms_div.sv
// bms_div: restoring divider, one quotient bit per cycle
`default_nettype none
module bms_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bms_pkg::div_req_t        req,
	output logic                          busy,
	output logic                          done,
	output logic [bms_pkg::QUO_W-1:0]     quo
);
	localparam int NW = bms_pkg::NUM_W;
	localparam int DW = bms_pkg::DEN_W;
	localparam int QW = bms_pkg::QUO_W;
	localparam int CW = $clog2(QW);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;

	assign trial = {rem_q, lo_q[QW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[NW-1:QW];
			lo_q  <= req.num[QW-1:0];
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			lo_q <= lo_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DW'(trial - {1'b0, den_q});
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= DW'(trial);
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

FILE: hdl/bump_map_shader_unit.sv
// bump_map_shader_unit: bump map shading correction, height store and query sequencer
// load: written to the height memory at the transfer edge if inside the map, loads go back to back
// query: from the transfer to m_tvalid it runs four neighbour reads, a square root,
// four divisions on one shared divider and a 14-step atan iteration; outside the map it gives shade 0
// one item at a time; the output register lets the next item in while a result waits
// after reset a clearing pass zeroes MAX_WIDTH*MAX_HEIGHT entries, one per cycle, before s_tready
`default_nettype none
module bump_map_shader_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // pos_x, pos_y, height_value
	input  wire logic        s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // shade
);
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam logic [8:0] W_RST = 9'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
	localparam logic [8:0] H_RST = 9'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);
	localparam int NW = bms_pkg::NUM_W;
	localparam int DW = bms_pkg::DEN_W;

	typedef enum logic [20:0] {
		ST_IDLE = 21'h000001,
		ST_READ = 21'h000002,
		ST_DIFF = 21'h000004,
		ST_SQA  = 21'h000008,
		ST_SQB  = 21'h000010,
		ST_SUM  = 21'h000020,
		ST_ROOT = 21'h000040,
		ST_DIV  = 21'h000080,
		ST_DOT1 = 21'h000100,
		ST_DOT2 = 21'h000200,
		ST_DOT3 = 21'h000400,
		ST_TSET = 21'h000800,
		ST_ATAN = 21'h001000,
		ST_QM1  = 21'h002000,
		ST_QR1  = 21'h004000,
		ST_QM2  = 21'h008000,
		ST_QR2  = 21'h010000,
		ST_TDIV = 21'h020000,
		ST_FIN1 = 21'h040000,
		ST_FIN2 = 21'h080000,
		ST_OUT  = 21'h100000
	} state_t;

	state_t state_q;
	logic [8:0]  width_q;
	logic [8:0]  height_q;
	logic [2:0]  rd_cnt_q;
	logic        rdv_s1;
	logic        okv_s1;
	logic [1:0]  idx_s1;
	logic [1:0]  div_sel_q;
	logic        div_go_q;
	logic        root_go_q;
	logic [3:0]  it_q;
	logic        mv_q;
	logic [7:0]  out_q;

	logic [7:0]  x_q;
	logic [7:0]  y_q;
	logic signed [15:0] h_q [4];
	logic signed [17:0] dx_q;
	logic signed [17:0] dy_q;
	logic [35:0] sqa_q;
	logic [35:0] sqb_q;
	logic [33:0] rr_q;
	logic [bms_pkg::ROOT_W-1:0] s_q;
	logic signed [16:0] nx_q;
	logic signed [16:0] ny_q;
	logic signed [16:0] nz_q;
	logic signed [47:0] pl_q;
	logic signed [47:0] ps_q;
	logic signed [19:0] dl_q;
	logic signed [19:0] ds_q;
	logic signed [23:0] cx_q;
	logic signed [23:0] cy_q;
	logic signed [17:0] cz_q;
	logic signed [18:0] q_q;
	logic [39:0] pq_q;
	logic [19:0] q2_q;
	logic [23:0] q4_q;
	logic [15:0] term_q;
	logic signed [23:0] w_q;
	logic signed [7:0]  res_q;

	logic in_xfer;
	logic out_load;
	logic in_map;
	logic [8:0] nb_col;
	logic [8:0] nb_row;
	logic nb_ok;
	logic [AW-1:0] nb_addr;
	logic [AW-1:0] ld_addr;
	logic st_we;
	logic [AW-1:0] st_addr;
	logic [15:0] st_rdata;
	logic st_ready;
	logic signed [17:0] dsrc;
	logic [17:0] dmag;
	logic [DW-1:0] tden;
	bms_pkg::div_req_t  div_req;
	bms_pkg::root_req_t root_req;
	logic div_busy;
	logic div_done;
	logic [bms_pkg::QUO_W-1:0] div_quo;
	logic root_done;
	logic [bms_pkg::ROOT_W-1:0] root_val;
	logic signed [16:0] nq;
	logic signed [18:0] dsum;
	logic signed [17:0] nsum;
	logic signed [23:0] xs;
	logic signed [23:0] ys;
	logic signed [19:0] vsum;
	logic [23:0] wmag;
	logic signed [10:0] shv;

	assign s_tready = st_ready && (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!mv_q || m_tready);
	assign in_map   = ({1'b0, s_tdata[7:0]} < width_q) && ({1'b0, s_tdata[15:8]} < height_q);
	assign ld_addr  = AW'(AW'(s_tdata[15:8]) * AW'(MAX_WIDTH) + AW'(s_tdata[7:0]));

	always_comb begin
		nb_col = {1'b0, x_q};
		nb_row = {1'b0, y_q};
		nb_ok  = 1'b0;
		unique case (rd_cnt_q[1:0])
			2'd0: begin
				nb_col = {1'b0, x_q} + 9'd1;
				nb_ok  = nb_col < width_q;
			end
			2'd1: begin
				nb_col = {1'b0, x_q} - 9'd1;
				nb_ok  = x_q != 8'd0;
			end
			2'd2: begin
				nb_row = {1'b0, y_q} + 9'd1;
				nb_ok  = nb_row < height_q;
			end
			default: begin
				nb_row = {1'b0, y_q} - 9'd1;
				nb_ok  = y_q != 8'd0;
			end
		endcase
		nb_addr = nb_ok ? AW'(AW'(nb_row) * AW'(MAX_WIDTH) + AW'(nb_col)) : '0;
	end

	always_comb begin
		st_we   = in_xfer && (s_tuser == bms_pkg::CMD_LOAD) && in_map;
		st_addr = (state_q == ST_READ) ? nb_addr : ld_addr;
	end

	bms_store #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (st_we),
		.addr  (st_addr),
		.wdata (s_tdata[31:16]),
		.rdata (st_rdata),
		.ready (st_ready)
	);

	always_comb begin
		unique case (div_sel_q)
			2'd0:    dsrc = dx_q;
			2'd1:    dsrc = dy_q;
			default: dsrc = 18'sd512;
		endcase
		dmag = dsrc[17] ? 18'(-dsrc) : 18'(dsrc);
		tden = DW'(q4_q) + DW'(16384);
		div_req.start = div_go_q;
		if (state_q == ST_TDIV) begin
			div_req.num = (NW'(1) << 28) + NW'(tden >> 1);
			div_req.den = tden;
		end else begin
			div_req.num = (NW'(dmag) << 22) + NW'(s_q >> 1);
			div_req.den = DW'(s_q);
		end
		root_req.start = root_go_q;
		root_req.rad   = {rr_q, 16'd0};
	end

	bms_root u_root (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (root_req),
		.done  (root_done),
		.root  (root_val)
	);

	bms_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		nq   = dsrc[17] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		dsum = 19'(nx_q) + 19'(ny_q) + 19'(nz_q);
		nsum = 18'(nx_q) + 18'(ny_q);
		xs   = cx_q >>> it_q;
		ys   = cy_q >>> it_q;
		vsum = 20'(cz_q) + $signed({4'b0, term_q}) - bms_pkg::V_FLAT;
		wmag = w_q[23] ? 24'(-w_q) : 24'(w_q);
		shv  = w_q[23] ? -$signed({1'b0, wmag[23:14]}) : $signed({1'b0, wmag[23:14]});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			width_q   <= W_RST;
			height_q  <= H_RST;
			rd_cnt_q  <= '0;
			rdv_s1    <= 1'b0;
			div_sel_q <= '0;
			div_go_q  <= 1'b0;
			root_go_q <= 1'b0;
			it_q      <= '0;
			mv_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bms_pkg::REG_WIDTH: begin
						if (cfg_data == 9'd0)
							width_q <= 9'd1;
						else if (32'(cfg_data) > MAX_WIDTH)
							width_q <= 9'(MAX_WIDTH);
						else
							width_q <= cfg_data;
					end
					default: begin
						if (cfg_data == 9'd0)
							height_q <= 9'd1;
						else if (32'(cfg_data) > MAX_HEIGHT)
							height_q <= 9'(MAX_HEIGHT);
						else
							height_q <= cfg_data;
					end
				endcase
			end
			if (out_load)
				mv_q <= 1'b1;
			else if (m_tready)
				mv_q <= 1'b0;
			div_go_q  <= 1'b0;
			root_go_q <= 1'b0;
			rdv_s1    <= (state_q == ST_READ) && (rd_cnt_q != 3'd4);
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (s_tuser == bms_pkg::CMD_QUERY)) begin
						rd_cnt_q <= '0;
						state_q  <= in_map ? ST_READ : ST_OUT;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 3'd1;
					if (rd_cnt_q == 3'd4)
						state_q <= ST_DIFF;
				end
				ST_DIFF: state_q <= ST_SQA;
				ST_SQA:  state_q <= ST_SQB;
				ST_SQB:  state_q <= ST_SUM;
				ST_SUM: begin
					root_go_q <= 1'b1;
					state_q   <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						div_sel_q <= '0;
						div_go_q  <= 1'b1;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (div_sel_q == 2'd2) begin
							state_q <= ST_DOT1;
						end else begin
							div_sel_q <= div_sel_q + 2'd1;
							div_go_q  <= 1'b1;
						end
					end
				end
				ST_DOT1: state_q <= ST_DOT2;
				ST_DOT2: state_q <= ST_DOT3;
				ST_DOT3: state_q <= ST_TSET;
				ST_TSET: begin
					it_q    <= '0;
					state_q <= ST_ATAN;
				end
				ST_ATAN: begin
					it_q <= it_q + 4'd1;
					if (it_q == bms_pkg::ATAN_LAST)
						state_q <= ST_QM1;
				end
				ST_QM1: state_q <= ST_QR1;
				ST_QR1: state_q <= ST_QM2;
				ST_QM2: state_q <= ST_QR2;
				ST_QR2: begin
					div_go_q <= 1'b1;
					state_q  <= ST_TDIV;
				end
				ST_TDIV: begin
					if (div_done)
						state_q <= ST_FIN1;
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		okv_s1 <= nb_ok;
		idx_s1 <= rd_cnt_q[1:0];
		if (rdv_s1)
			h_q[idx_s1] <= okv_s1 ? $signed(st_rdata) : 16'sd0;
		if (out_load)
			out_q <= res_q;
		unique case (state_q)
			ST_IDLE: begin
				x_q   <= s_tdata[7:0];
				y_q   <= s_tdata[15:8];
				res_q <= 8'sd0;
			end
			ST_DIFF: begin
				dx_q <= 18'(h_q[0]) - 18'(h_q[1]);
				dy_q <= 18'(h_q[2]) - 18'(h_q[3]);
			end
			ST_SQA: sqa_q <= 36'(dx_q * dx_q);
			ST_SQB: sqb_q <= 36'(dy_q * dy_q);
			ST_SUM: rr_q  <= 34'(sqa_q + sqb_q + 36'd262144);
			ST_ROOT: begin
				if (root_done)
					s_q <= root_val;
			end
			ST_DIV: begin
				if (div_done) begin
					unique case (div_sel_q)
						2'd0:    nx_q <= nq;
						2'd1:    ny_q <= nq;
						default: nz_q <= nq;
					endcase
				end
			end
			ST_DOT1: begin
				pl_q <= 48'(dsum) * 48'(bms_pkg::L_COMP);
				ps_q <= 48'(nsum) * 48'(bms_pkg::S_XY);
			end
			ST_DOT2: ps_q <= ps_q - 48'(nz_q) * 48'(bms_pkg::S_Z);
			ST_DOT3: begin
				dl_q <= 20'(bms_pkg::rnd_q14(pl_q));
				ds_q <= 20'(bms_pkg::rnd_q14(ps_q));
			end
			ST_TSET: begin
				cx_q <= 24'sd16384;
				cy_q <= 24'(dl_q - bms_pkg::DOT_BIAS) * 24'sd5;
				cz_q <= 18'sd0;
				q_q  <= 19'(ds_q) * 19'sd4;
			end
			ST_ATAN: begin
				if (cy_q > 24'sd0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + bms_pkg::atan_step(it_q);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - bms_pkg::atan_step(it_q);
				end
			end
			ST_QM1: pq_q <= 40'(38'(q_q) * 38'(q_q));
			ST_QR1: q2_q <= 20'(bms_pkg::rnd_q14($signed({8'd0, pq_q})));
			ST_QM2: pq_q <= 40'(q2_q) * 40'(q2_q);
			ST_QR2: q4_q <= 24'(bms_pkg::rnd_q14($signed({8'd0, pq_q})));
			ST_TDIV: begin
				if (div_done)
					term_q <= div_quo;
			end
			ST_FIN1: w_q <= 24'(vsum) * 24'sd20 + 24'sd8192;
			ST_FIN2: begin
				if (shv > 11'sd127)
					res_q <= 8'sd127;
				else if (shv < -11'sd128)
					res_q <= -8'sd128;
				else
					res_q <= 8'(shv);
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = out_q;

	a_idle_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> st_ready)
		else $error("input taken during clearing pass");

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_busy)
		else $error("divider started while busy");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!mv_q || m_tready))
		else $error("pending result overwritten");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (state_q == ST_IDLE))
		else $error("map write outside idle");

endmodule
`default_nettype wire
